@@ hw/rtl/bdeq_pkg.sv @@
package bdeq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_QUERY      = 3'd4;

  localparam int CAP_W = 11;
  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  localparam logic [0:0] REG_CAPACITY = 1'd0;

  localparam logic signed [31:0] EMPTY_VALUE = -32'sd1;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] front_value;
    logic signed [31:0] rear_value;
    logic               is_empty;
    logic               is_full;
  } result_t;

endpackage

@@ hw/rtl/bounded_double_ended_queue.sv @@
// Circular double-ended queue of DEPTH signed 32-bit entries. One request
// (push front, push rear, pop front, pop rear or status query; codes 5 to 7
// act as a query) is accepted every cycle while in_stall is low, and its
// result is registered in the output stage. Front and rear entries are held
// in registers, and their neighbors are prefetched from the entry memory
// through its two read ports, so consecutive pops at either end need not
// wait for a read. A two-deep output stage lets a request be taken while
// an earlier result is stalled; in_stall rises only when both are full.
// The capacity limit (APB, byte address 0) saturates at DEPTH; a value of
// zero makes the queue both empty and full. The memory needs no clearing
// after reset and the block takes requests from the first cycle on.
module bounded_double_ended_queue #(
  parameter int DEPTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                operation,
  input  logic signed [31:0]        value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      ok,
  output logic signed [31:0]        front_value,
  output logic signed [31:0]        rear_value,
  output logic                      is_empty,
  output logic                      is_full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                              input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_A) begin
      s = s - DEPTH_A;
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] a);
    logic [AW:0] d;
    d = DEPTH_A - (AW+1)'(1);
    if (a == '0) begin
      return d[AW-1:0];
    end
    return a - AW'(1);
  endfunction

  logic [bdeq_pkg::CAP_W-1:0] capacity;

  logic [31:0]        mem [0:DEPTH-1];
  logic [AW-1:0]      head, head_next;
  logic [CW-1:0]      count, count_next;
  logic signed [31:0] front, front_next;
  logic signed [31:0] rear, rear_next;
  logic signed [31:0] nf;
  logic signed [31:0] nr;

  logic               out_reg_valid;
  bdeq_pkg::result_t  out_reg;
  logic               sk_valid;
  bdeq_pkg::result_t  sk;
  bdeq_pkg::result_t  res;

  logic               produce;
  logic               full, empty, full_next, empty_next;
  logic               is_pf, is_pr, is_qf, is_qr;
  logic               do_pf, do_pr, do_qf, do_qr;
  logic               we;
  logic [AW-1:0]      wa;
  logic [AW-1:0]      ra_f, ra_r;
  logic [CW-1:0]      off_r;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == bdeq_pkg::REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bdeq_pkg::CAP_RESET;
    end else if (cfg_write && paddr[2] == bdeq_pkg::REG_CAPACITY) begin
      capacity <= pwdata[bdeq_pkg::CAP_W-1:0];
    end
  end

  assign in_stall = sk_valid;
  assign produce  = in_valid && !sk_valid;

  always_comb begin
    is_pf = (operation == bdeq_pkg::OP_PUSH_FRONT);
    is_pr = (operation == bdeq_pkg::OP_PUSH_REAR);
    is_qf = (operation == bdeq_pkg::OP_POP_FRONT);
    is_qr = (operation == bdeq_pkg::OP_POP_REAR);

    empty = (count == '0);
    full  = (MW'(count) >= MW'(capacity)) || (count == DEPTH_C);

    do_pf = produce && is_pf && !full;
    do_pr = produce && is_pr && !full;
    do_qf = produce && is_qf && !empty;
    do_qr = produce && is_qr && !empty;

    head_next  = head;
    count_next = count;
    front_next = front;
    rear_next  = rear;
    we         = do_pf || do_pr;
    wa         = do_pf ? wrap_dec(head) : wrap_add(head, count[AW-1:0]);

    if (do_pf) begin
      head_next  = wrap_dec(head);
      count_next = count + CW'(1);
      front_next = value;
      if (empty) begin
        rear_next = value;
      end
    end else if (do_pr) begin
      count_next = count + CW'(1);
      rear_next  = value;
      if (empty) begin
        front_next = value;
      end
    end else if (do_qf) begin
      head_next  = wrap_add(head, AW'(1));
      count_next = count - CW'(1);
      front_next = nf;
    end else if (do_qr) begin
      count_next = count - CW'(1);
      rear_next  = nr;
    end

    empty_next = (count_next == '0);
    full_next  = (MW'(count_next) >= MW'(capacity)) || (count_next == DEPTH_C);

    off_r = (count_next >= CW'(2)) ? (count_next - CW'(2)) : '0;
    ra_f  = wrap_add(head_next, AW'(1));
    ra_r  = wrap_add(head_next, off_r[AW-1:0]);

    res.ok          = !((is_pf || is_pr) && full) && !((is_qf || is_qr) && empty);
    res.front_value = empty_next ? bdeq_pkg::EMPTY_VALUE : front_next;
    res.rear_value  = empty_next ? bdeq_pkg::EMPTY_VALUE : rear_next;
    res.is_empty    = empty_next;
    res.is_full     = full_next;
  end

  // entry memory: one write port, two prefetch read ports with write bypass
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= value;
    end
    nf <= (we && wa == ra_f) ? value : mem[ra_f];
    nr <= (we && wa == ra_r) ? value : mem[ra_r];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
    front <= front_next;
    rear  <= rear_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_reg_valid <= 1'b0;
      sk_valid      <= 1'b0;
    end else if (!out_reg_valid || !out_stall) begin
      if (sk_valid) begin
        out_reg_valid <= 1'b1;
        sk_valid      <= 1'b0;
      end else begin
        out_reg_valid <= produce;
      end
    end else if (produce) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_reg_valid || !out_stall) begin
      out_reg <= sk_valid ? sk : res;
    end else if (produce) begin
      sk <= res;
    end
  end

  assign out_valid   = out_reg_valid;
  assign ok          = out_reg.ok;
  assign front_value = out_reg.front_value;
  assign rear_value  = out_reg.rear_value;
  assign is_empty    = out_reg.is_empty;
  assign is_full     = out_reg.is_full;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int QDEPTH = 1024;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [2:0] OP_RSVD_A = 3'd5;
  localparam logic [2:0] OP_RSVD_B = 3'd6;
  localparam logic [2:0] OP_RSVD_C = 3'd7;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] val;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = bdeq_pkg::OP_QUERY;
  logic signed [31:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic ok;
  logic signed [31:0] front_value;
  logic signed [31:0] rear_value;
  logic is_empty;
  logic is_full;

  request_t req_pending[$];
  bdeq_pkg::result_t status_due[$];
  bdeq_pkg::result_t want;

  // shadow of the deque
  logic signed [31:0] dq_mem [QDEPTH];
  logic [9:0] dq_head = '0;
  logic [10:0] dq_count = '0;
  logic [10:0] dq_cap = bdeq_pkg::CAP_RESET;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet = 0;
  int errors = 0;

  bounded_double_ended_queue #(.DEPTH(QDEPTH)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .operation(operation), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .ok(ok),
    .front_value(front_value), .rear_value(rear_value),
    .is_empty(is_empty), .is_full(is_full)
  );

  always #2 clk = ~clk;

  function automatic void apply_request(request_t r);
    logic [10:0] lim;
    logic was_full;
    logic was_empty;
    logic [9:0] idx;
    bdeq_pkg::result_t res;
    lim = (dq_cap > 11'd1024) ? 11'd1024 : dq_cap;
    was_full = dq_count >= lim;
    was_empty = dq_count == 11'd0;
    res.ok = 1'b1;
    case (r.op)
      bdeq_pkg::OP_PUSH_FRONT: begin
        if (was_full) begin
          res.ok = 1'b0;
        end else begin
          dq_head = dq_head - 10'd1;
          dq_mem[dq_head] = r.val;
          dq_count = dq_count + 11'd1;
        end
      end
      bdeq_pkg::OP_PUSH_REAR: begin
        if (was_full) begin
          res.ok = 1'b0;
        end else begin
          idx = dq_head + dq_count[9:0];
          dq_mem[idx] = r.val;
          dq_count = dq_count + 11'd1;
        end
      end
      bdeq_pkg::OP_POP_FRONT: begin
        if (was_empty) begin
          res.ok = 1'b0;
        end else begin
          dq_head = dq_head + 10'd1;
          dq_count = dq_count - 11'd1;
        end
      end
      bdeq_pkg::OP_POP_REAR: begin
        if (was_empty) begin
          res.ok = 1'b0;
        end else begin
          dq_count = dq_count - 11'd1;
        end
      end
      default: ;
    endcase
    res.is_empty = dq_count == 11'd0;
    res.is_full = dq_count >= lim;
    if (res.is_empty) begin
      res.front_value = bdeq_pkg::EMPTY_VALUE;
      res.rear_value = bdeq_pkg::EMPTY_VALUE;
    end else begin
      idx = dq_head + dq_count[9:0] - 10'd1;
      res.front_value = dq_mem[dq_head];
      res.rear_value = dq_mem[idx];
    end
    status_due.push_back(res);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch %s: got %h want %h at %0t", what, got, exp_val, $realtime);
    errors++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(req_pending.pop_front());
      end
      if (in_valid && in_stall) begin
      end else if (req_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        operation <= req_pending[0].op;
        value <= req_pending[0].val;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall, with optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (status_due.size() == 0) begin
        report_mismatch("unexpected result", 32'({ok, is_empty, is_full}), '0);
      end else begin
        want = status_due.pop_front();
        if (ok !== want.ok) report_mismatch("ok", 32'(ok), 32'(want.ok));
        if (front_value !== want.front_value)
          report_mismatch("front_value", front_value, want.front_value);
        if (rear_value !== want.rear_value)
          report_mismatch("rear_value", rear_value, want.rear_value);
        if (is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(is_empty), 32'(want.is_empty));
        if (is_full !== want.is_full)
          report_mismatch("is_full", 32'(is_full), 32'(want.is_full));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("bounded_double_ended_queue verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic enqueue_req(logic [2:0] op, logic signed [31:0] val);
    request_t r;
    r.op = op;
    r.val = val;
    req_pending.push_back(r);
  endtask

  task automatic enqueue_random(int n, int push_pct);
    int r;
    logic signed [31:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 15))
        0: v = VAL_MAX;
        1: v = VAL_MIN;
        2: v = 32'sd0;
        3: v = -32'sd1;
        default: v = $urandom;
      endcase
      r = $urandom_range(0, 99);
      if (r < push_pct)
        enqueue_req($urandom_range(0, 1) ? bdeq_pkg::OP_PUSH_REAR : bdeq_pkg::OP_PUSH_FRONT, v);
      else if (r < 96)
        enqueue_req($urandom_range(0, 1) ? bdeq_pkg::OP_POP_REAR : bdeq_pkg::OP_POP_FRONT, v);
      else
        enqueue_req(3'($urandom_range(4, 7)), v);
    end
  endtask

  task automatic drain_results();
    while (req_pending.size() != 0 || status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [10:0] cap);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {bdeq_pkg::REG_CAPACITY, 2'b00};
    pwdata <= {21'd0, cap};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    dq_cap = cap;
    @(negedge clk);
    if (prdata !== {21'd0, cap}) report_mismatch("capacity readback", prdata, {21'd0, cap});
  endtask

  task automatic set_idle(int k);
    case (k % 4)
      0: begin send_idle_pct = 0; stall_pct = 0; end
      1: begin send_idle_pct = 62; stall_pct = 0; end
      2: begin send_idle_pct = 0; stall_pct = 62; end
      default: begin send_idle_pct = 27; stall_pct = 27; end
    endcase
  endtask

  initial begin
    logic [10:0] caps [8];
    caps = '{11'd5, 11'd3, 11'd16, 11'd1, 11'd1024, 11'd2, 11'd7, 11'd1024};
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset capacity: empty pops, extremes, unused codes
    enqueue_req(bdeq_pkg::OP_QUERY, 32'sd0);
    enqueue_req(bdeq_pkg::OP_POP_FRONT, 32'sd0);
    enqueue_req(bdeq_pkg::OP_POP_REAR, 32'sd0);
    enqueue_req(bdeq_pkg::OP_PUSH_FRONT, VAL_MAX);
    enqueue_req(bdeq_pkg::OP_PUSH_REAR, VAL_MIN);
    enqueue_req(bdeq_pkg::OP_PUSH_FRONT, 32'sd0);
    enqueue_req(bdeq_pkg::OP_PUSH_REAR, -32'sd1);
    enqueue_req(OP_RSVD_A, 32'sd0);
    enqueue_req(OP_RSVD_B, VAL_MAX);
    enqueue_req(OP_RSVD_C, VAL_MIN);
    enqueue_req(bdeq_pkg::OP_POP_FRONT, 32'sd0);
    enqueue_req(bdeq_pkg::OP_POP_REAR, 32'sd0);
    enqueue_req(bdeq_pkg::OP_POP_REAR, 32'sd0);
    enqueue_req(bdeq_pkg::OP_POP_FRONT, 32'sd0);
    enqueue_req(bdeq_pkg::OP_POP_FRONT, 32'sd0);
    drain_results();

    write_capacity(11'd1);
    enqueue_req(bdeq_pkg::OP_PUSH_REAR, 32'sd17);
    enqueue_req(bdeq_pkg::OP_PUSH_REAR, 32'sd18);
    enqueue_req(bdeq_pkg::OP_POP_REAR, 32'sd0);
    enqueue_req(bdeq_pkg::OP_PUSH_FRONT, -32'sd5);
    enqueue_req(bdeq_pkg::OP_PUSH_FRONT, 32'sd6);
    enqueue_req(bdeq_pkg::OP_POP_FRONT, 32'sd0);
    drain_results();

    // zero capacity: empty and full at once
    write_capacity(11'd0);
    enqueue_req(bdeq_pkg::OP_PUSH_FRONT, 32'sd1);
    enqueue_req(bdeq_pkg::OP_PUSH_REAR, 32'sd2);
    enqueue_req(bdeq_pkg::OP_QUERY, 32'sd0);
    enqueue_req(bdeq_pkg::OP_POP_FRONT, 32'sd0);
    drain_results();

    // count left above a lowered capacity
    write_capacity(11'd16);
    for (int i = 0; i < 12; i++) enqueue_req(bdeq_pkg::OP_PUSH_REAR, $urandom);
    drain_results();
    write_capacity(11'd3);
    enqueue_random(40, 50);
    drain_results();

    for (int p = 0; p < 8; p++) begin
      write_capacity(caps[p]);
      set_idle(p);
      enqueue_random(25, 55);
      drain_results();
    end

    // saturated capacity: fill to full, wrap, then drain
    write_capacity(11'd2047);
    set_idle(3);
    enqueue_random(1150, 95);
    drain_results();
    set_idle(1);
    enqueue_random(100, 20);
    drain_results();
    set_idle(2);
    enqueue_random(50, 45);
    drain_results();

    // long receiver hold-off while requests keep coming
    write_capacity(11'd1024);
    set_idle(0);
    hold_left = 300;
    enqueue_random(60, 60);
    drain_results();

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("bounded_double_ended_queue verification clean");
    end else begin
      $display("bounded_double_ended_queue verification failed");
    end
    $finish;
  end

endmodule
